// ===== hw/rtl/mit_pkg.sv =====
// shared types and constants for the microsecond interval timer
// no dependencies; used by microsecond_interval_timer

package mit_pkg;

    // command codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_ACK   = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // register indexes on the apb port
    localparam logic REG_CLOCK_MHZ = 1'b0;
    localparam logic REG_ONE_PULSE = 1'b1;

    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int PSC_W               = 16;
    localparam int TIME_W              = 32;
    localparam int MHZ_W               = 8;
    localparam int ELAPSED_W           = 33;
    localparam int IN_DATA_W           = 32;
    localparam int OUT_DATA_W          = 40;

    localparam logic [MHZ_W-1:0]     MHZ_RESET    = 8'd72;
    localparam logic [PSC_W+1:0]     PRESCALE_MAX = 18'd65536;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 33'h1_FFFF_FFFF;

endpackage

// ===== hw/rtl/microsecond_interval_timer.sv =====
// microsecond interval timer: command-driven prescaled auto-reload timer
// depends on mit_pkg; one sequencer drives a shared add/subtract unit
//
//  channel | direction | signals                         | content
//  s_*     | in        | s_tvalid s_tready s_tuser s_tdata | command, period in us
//  m_*     | out       | m_tvalid m_tready m_tdata       | status and elapsed time
//  apb     | in/out    | psel penable pwrite paddr ...   | clock_mhz, one_pulse
//
// tick, stop, acknowledge and unused commands are handled on acceptance; the result is
// registered at the accepting edge
// start halves the count at most 32 - COUNT_WIDTH times,
// one halving of the count per cycle
// read runs restoring division by the clock rate, one
// quotient bit a cycle, then shift-add multiply, both on the shared adder
// no new request is taken while a result waits on a stalled m_tready
// reset clears all counters, reloads and flags; clock_mhz resets to 72

module microsecond_interval_timer #(
    parameter int COUNT_WIDTH = mit_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2:0]                     s_tuser,   // [2:0] command
    input  logic [mit_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] time_us
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] update_event, [1] update_flag, [2] running, [35:3] elapsed_us,
    // [36] range_error, [39:37] zero
    output logic [mit_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int QW      = mit_pkg::PSC_W + 1;
    localparam int STEP_W  = $clog2(QW);
    localparam int PROD_W  = QW + COUNT_WIDTH + 1;
    localparam int ACC_W   = (PROD_W > mit_pkg::ELAPSED_W + 1) ? PROD_W
                                                               : mit_pkg::ELAPSED_W + 1;
    localparam int PSCF_W  = mit_pkg::PSC_W + 2;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_NORM   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            kind_read_reg, kind_read_next;

    logic [mit_pkg::MHZ_W-1:0]       mhz_reg;
    logic                            one_pulse_reg;

    logic [mit_pkg::PSC_W-1:0]       psc_rld_reg, psc_rld_next;
    logic [mit_pkg::PSC_W-1:0]       psc_cnt_reg, psc_cnt_next;
    logic [COUNT_WIDTH-1:0]          per_rld_reg, per_rld_next;
    logic [COUNT_WIDTH-1:0]          per_cnt_reg, per_cnt_next;
    logic                            run_reg, run_next;
    logic                            flag_reg, flag_next;

    logic [mit_pkg::TIME_W-1:0]      cnt_reg, cnt_next;
    logic [PSCF_W-1:0]               pscf_reg, pscf_next;
    logic [QW-1:0]                   q_reg, q_next;
    logic [mit_pkg::MHZ_W-1:0]       rem_reg, rem_next;
    logic [ACC_W-1:0]                acc_reg, acc_next;
    logic [ACC_W-1:0]                mcand_reg, mcand_next;
    logic [STEP_W-1:0]               step_reg, step_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [mit_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // shared adder / subtractor
    logic [ACC_W-1:0]                alu_a, alu_b;
    logic                            alu_sub;
    logic [ACC_W:0]                  alu_sum;

    mit_pkg::cmd_t                   cmd;
    logic                            accept;
    logic                            out_free;
    logic [mit_pkg::MHZ_W-1:0]       mhz_eff;
    logic [mit_pkg::MHZ_W:0]         div_shift;
    logic                            cfg_write;
    logic                            sat;
    logic [mit_pkg::ELAPSED_W-1:0]   elapsed;
    logic                            evt;

    assign cmd       = mit_pkg::cmd_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign mhz_eff   = (mhz_reg == '0) ? mit_pkg::MHZ_W'(1) : mhz_reg;
    assign div_shift = {rem_reg, q_reg[QW-1]};
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == mit_pkg::REG_ONE_PULSE) ? {31'd0, one_pulse_reg}
                                                            : {24'd0, mhz_reg};

    assign sat     = pscf_reg > mit_pkg::PRESCALE_MAX;
    assign elapsed = (acc_reg > ACC_W'(mit_pkg::ELAPSED_MAX)) ? mit_pkg::ELAPSED_MAX
                                                              : acc_reg[mit_pkg::ELAPSED_W-1:0];

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        if (state_reg == ST_DIV)
        begin
            alu_a   = ACC_W'(div_shift);
            alu_b   = ACC_W'(mhz_eff);
            alu_sub = 1'b1;
        end
        alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ACC_W + 1)'(alu_sub);
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_read_next = kind_read_reg;
        psc_rld_next   = psc_rld_reg;
        psc_cnt_next   = psc_cnt_reg;
        per_rld_next   = per_rld_reg;
        per_cnt_next   = per_cnt_reg;
        run_next       = run_reg;
        flag_next      = flag_reg;
        cnt_next       = cnt_reg;
        pscf_next      = pscf_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        step_next      = step_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        evt            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        mit_pkg::CMD_TICK:
                        begin
                            if (run_reg)
                            begin
                                if (psc_cnt_reg == psc_rld_reg)
                                begin
                                    psc_cnt_next = '0;
                                    if (per_cnt_reg == per_rld_reg)
                                    begin
                                        per_cnt_next = '0;
                                        evt          = 1'b1;
                                        flag_next    = 1'b1;
                                        if (one_pulse_reg)
                                            run_next = 1'b0;
                                    end
                                    else
                                        per_cnt_next = per_cnt_reg + COUNT_WIDTH'(1);
                                end
                                else
                                    psc_cnt_next = psc_cnt_reg + mit_pkg::PSC_W'(1);
                            end
                        end
                        mit_pkg::CMD_START:
                        begin
                            cnt_next       = (s_tdata == '0) ? mit_pkg::TIME_W'(1) : s_tdata;
                            pscf_next      = PSCF_W'(mhz_eff);
                            kind_read_next = 1'b0;
                            state_next     = ST_NORM;
                        end
                        mit_pkg::CMD_STOP:
                        begin
                            run_next  = 1'b0;
                            flag_next = 1'b0;
                        end
                        mit_pkg::CMD_ACK:
                            flag_next = 1'b0;
                        mit_pkg::CMD_READ:
                        begin
                            q_next         = QW'(psc_rld_reg) + QW'(1);
                            rem_next       = '0;
                            step_next      = '0;
                            kind_read_next = 1'b1;
                            state_next     = ST_DIV;
                        end
                        default:
                        begin
                        end
                    endcase
                    // commands other than start and read report at once
                    if (cmd != mit_pkg::CMD_START && cmd != mit_pkg::CMD_READ)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {4'd0, 33'd0, run_next, flag_next, evt};
                    end
                end
            end
            ST_NORM:
            begin
                // halve the count and double the prescale, unless saturated, until the count fits
                if (((mit_pkg::TIME_W + 1)'(cnt_reg) >> COUNT_WIDTH) != '0)
                begin
                    cnt_next  = cnt_reg >> 1;
                    pscf_next = sat ? pscf_reg : (pscf_reg << 1);
                end
                else
                    state_next = ST_FINISH;
            end
            ST_DIV:
            begin
                q_next   = {q_reg[QW-2:0], alu_sum[ACC_W]};
                rem_next = alu_sum[ACC_W] ? alu_sum[mit_pkg::MHZ_W-1:0]
                                          : div_shift[mit_pkg::MHZ_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    mcand_next = ACC_W'({1'b0, per_cnt_reg} + (COUNT_WIDTH + 1)'(1));
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (q_reg[0])
                    acc_next = alu_sum[ACC_W-1:0];
                mcand_next = mcand_reg << 1;
                q_next     = q_reg >> 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (kind_read_reg)
                        m_tdata_next = {4'd0, elapsed, run_reg, flag_reg, 1'b0};
                    else
                    begin
                        psc_rld_next = sat ? '1 : mit_pkg::PSC_W'(pscf_reg - PSCF_W'(1));
                        per_rld_next = COUNT_WIDTH'(cnt_reg - mit_pkg::TIME_W'(1));
                        psc_cnt_next = '0;
                        per_cnt_next = '0;
                        run_next     = 1'b1;
                        m_tdata_next = {3'd0, sat, 33'd0, 1'b1, flag_reg, 1'b0};
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_read_reg <= 1'b0;
            mhz_reg       <= mit_pkg::MHZ_RESET;
            one_pulse_reg <= 1'b0;
            psc_rld_reg   <= '0;
            psc_cnt_reg   <= '0;
            per_rld_reg   <= '0;
            per_cnt_reg   <= '0;
            run_reg       <= 1'b0;
            flag_reg      <= 1'b0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_read_reg <= kind_read_next;
            psc_rld_reg   <= psc_rld_next;
            psc_cnt_reg   <= psc_cnt_next;
            per_rld_reg   <= per_rld_next;
            per_cnt_reg   <= per_cnt_next;
            run_reg       <= run_next;
            flag_reg      <= flag_next;
            step_reg      <= step_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_write)
            begin
                if (paddr[2] == mit_pkg::REG_CLOCK_MHZ)
                    mhz_reg <= pwdata[mit_pkg::MHZ_W-1:0];
                else
                    one_pulse_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        pscf_reg    <= pscf_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        m_tdata_reg <= m_tdata_next;
    end

    // no request is taken while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request taken while sequencer busy");

    // a start request always moves on to normalisation
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == mit_pkg::CMD_START) |=> (state_reg == ST_NORM))
        else $error("start did not enter normalisation");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < mhz_eff))
        else $error("division remainder out of range");

    // counters never pass their reloads
    assert property (@(posedge clk) disable iff (!rst_n)
        (psc_cnt_reg <= psc_rld_reg) && (per_cnt_reg <= per_rld_reg))
        else $error("counter beyond reload");

endmodule
